// ----- src/asmtok_pkg.sv -----
package asmtok_pkg;

  localparam int POS_BITS  = 20;
  localparam int LINE_BITS = 16;
  localparam int COL_BITS  = 12;
  localparam int LEN_BITS  = 20;
  localparam int KIND_BITS = 4;
  localparam int SLOTS     = 4;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [POS_BITS-1:0]  POS_MAX  = {POS_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_NEWLINE = 4'd0,
    KIND_DOT     = 4'd1,
    KIND_COLON   = 4'd2,
    KIND_COMMA   = 4'd3,
    KIND_PLUS    = 4'd4,
    KIND_MINUS   = 4'd5,
    KIND_LPAR    = 4'd6,
    KIND_RPAR    = 4'd7,
    KIND_IDENT   = 4'd8,
    KIND_INT     = 4'd9,
    KIND_END     = 4'd10,
    KIND_ERROR   = 4'd11
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_DEC     = 3'd3,
    MODE_HEXPRE  = 3'd4,
    MODE_HEX     = 3'd5
  } scan_mode_t;

  typedef struct packed {
    tok_kind_t             kind;
    logic [POS_BITS-1:0]   start;
    logic [LINE_BITS-1:0]  line;
    logic [COL_BITS-1:0]   column;
    logic [LEN_BITS-1:0]   length;
  } tok_t;

  // One character's tokens: close, single/error, flush, end (in that order)
  typedef struct packed {
    logic [SLOTS-1:0]  vld;
    tok_t [SLOTS-1:0]  tok;
  } bundle_t;

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return c inside {[8'h41:8'h5a], [8'h61:8'h7a]} || c == CH_UNDER;
  endfunction

  function automatic logic is_ident_mid(input logic [7:0] c);
    return is_dec(c) || is_ident_start(c);
  endfunction

endpackage

// ----- src/asmtok_front.sv -----
module asmtok_front
  import asmtok_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    in_ch,
  input  logic          in_source_end,
  output logic          q_push,
  output bundle_t       q_data
);

  scan_mode_t           mode_r, mode_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [COL_BITS-1:0]  col_r, col_nxt;
  logic [POS_BITS-1:0]  ost_r, ost_nxt;
  logic [LINE_BITS-1:0] oln_r, oln_nxt;
  logic [COL_BITS-1:0]  ocl_r, ocl_nxt;
  logic                 lone_zero_r, lone_zero_nxt;
  logic                 halted_r, halted_nxt;

  logic                 cont, close_v, hex_fail, single_v, unknown, opens, term;
  tok_kind_t            close_kind, single_kind;
  scan_mode_t           mode_cont, mode_new, mode_mid;
  logic [POS_BITS-1:0]  pos_a, ost_mid;
  logic [LINE_BITS-1:0] line_a, oln_mid;
  logic [COL_BITS-1:0]  col_a, ocl_mid;
  logic                 flush_open;

  // Classify the character against the open token
  always_comb begin : classify
    cont       = 1'b0;
    close_v    = 1'b0;
    close_kind = KIND_INT;
    hex_fail   = 1'b0;
    mode_cont  = mode_r;
    case (mode_r)
      MODE_COMMENT: cont = (in_ch != CH_LF);
      MODE_IDENT: begin
        cont       = is_ident_mid(in_ch);
        close_v    = !cont;
        close_kind = KIND_IDENT;
      end
      MODE_DEC: begin
        if (is_dec(in_ch)) begin
          cont = 1'b1;
        end else if (lone_zero_r && (in_ch == CH_X_LO || in_ch == CH_X_UP)) begin
          cont      = 1'b1;
          mode_cont = MODE_HEXPRE;
        end else begin
          close_v = 1'b1;
        end
      end
      MODE_HEXPRE: begin
        if (is_hex(in_ch)) begin
          cont      = 1'b1;
          mode_cont = MODE_HEX;
        end else begin
          close_v    = 1'b1;
          close_kind = KIND_ERROR;
          hex_fail   = 1'b1;
        end
      end
      MODE_HEX: begin
        cont    = is_hex(in_ch);
        close_v = !cont;
      end
      default: ;
    endcase

    single_v    = 1'b0;
    single_kind = KIND_NEWLINE;
    unknown     = 1'b0;
    opens       = 1'b0;
    mode_new    = MODE_IDLE;
    case (in_ch)
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_HASH:  mode_new = MODE_COMMENT;
      CH_LF:    single_v = 1'b1;
      CH_DOT:   begin single_v = 1'b1; single_kind = KIND_DOT;   end
      CH_COLON: begin single_v = 1'b1; single_kind = KIND_COLON; end
      CH_COMMA: begin single_v = 1'b1; single_kind = KIND_COMMA; end
      CH_PLUS:  begin single_v = 1'b1; single_kind = KIND_PLUS;  end
      CH_MINUS: begin single_v = 1'b1; single_kind = KIND_MINUS; end
      CH_LPAR:  begin single_v = 1'b1; single_kind = KIND_LPAR;  end
      CH_RPAR:  begin single_v = 1'b1; single_kind = KIND_RPAR;  end
      default: begin
        if (is_ident_start(in_ch)) begin
          mode_new = MODE_IDENT;
          opens    = 1'b1;
        end else if (is_dec(in_ch)) begin
          mode_new = MODE_DEC;
          opens    = 1'b1;
        end else begin
          unknown = 1'b1;
        end
      end
    endcase

    term     = hex_fail || (!cont && unknown);
    mode_mid = cont ? mode_cont : mode_new;
    if (!cont && opens) begin
      ost_mid = pos_r;
      oln_mid = line_r;
      ocl_mid = col_r;
    end else begin
      ost_mid = ost_r;
      oln_mid = oln_r;
      ocl_mid = ocl_r;
    end

    // Saturating counters
    pos_a = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    if (in_ch == CH_LF) begin
      line_a = (line_r == LINE_MAX) ? line_r : line_r + 1'b1;
      col_a  = '0;
    end else begin
      line_a = line_r;
      col_a  = (col_r == COL_MAX) ? col_r : col_r + 1'b1;
    end
    flush_open = (mode_mid == MODE_IDENT) || (mode_mid == MODE_DEC) ||
                 (mode_mid == MODE_HEX) || (mode_mid == MODE_HEXPRE);
  end

  always_comb begin : next_state
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    ost_nxt       = ost_r;
    oln_nxt       = oln_r;
    ocl_nxt       = ocl_r;
    lone_zero_nxt = lone_zero_r;
    halted_nxt    = halted_r;
    if (step_en) begin
      if (in_source_end) begin
        // end of source always returns to the reset state
        mode_nxt      = MODE_IDLE;
        pos_nxt       = '0;
        line_nxt      = '0;
        col_nxt       = '0;
        ost_nxt       = '0;
        oln_nxt       = '0;
        ocl_nxt       = '0;
        lone_zero_nxt = 1'b0;
        halted_nxt    = 1'b0;
      end else if (!halted_r) begin
        if (term) begin
          halted_nxt = 1'b1;
        end else begin
          mode_nxt      = mode_mid;
          pos_nxt       = pos_a;
          line_nxt      = line_a;
          col_nxt       = col_a;
          ost_nxt       = ost_mid;
          oln_nxt       = oln_mid;
          ocl_nxt       = ocl_mid;
          lone_zero_nxt = !cont && (in_ch == CH_ZERO);
        end
      end
    end
  end

  always_comb begin : outputs
    q_data = '0;

    q_data.vld[0]           = !halted_r && close_v;
    q_data.tok[0].kind      = close_kind;
    q_data.tok[0].start     = ost_r;
    q_data.tok[0].line      = oln_r;
    q_data.tok[0].column    = ocl_r;
    q_data.tok[0].length    = (close_kind == KIND_ERROR) ? '0 : LEN_BITS'(pos_r - ost_r);

    q_data.vld[1]           = !halted_r && !hex_fail && !cont && (single_v || unknown);
    q_data.tok[1].kind      = unknown ? KIND_ERROR : single_kind;
    q_data.tok[1].start     = pos_r;
    q_data.tok[1].line      = line_r;
    q_data.tok[1].column    = col_r;
    q_data.tok[1].length    = unknown ? '0 : LEN_BITS'(1);

    q_data.vld[2]           = !halted_r && in_source_end && !term && flush_open;
    q_data.tok[2].kind      = (mode_mid == MODE_IDENT)  ? KIND_IDENT :
                              (mode_mid == MODE_HEXPRE) ? KIND_ERROR : KIND_INT;
    q_data.tok[2].start     = ost_mid;
    q_data.tok[2].line      = oln_mid;
    q_data.tok[2].column    = ocl_mid;
    q_data.tok[2].length    = (mode_mid == MODE_HEXPRE) ? '0 : LEN_BITS'(pos_a - ost_mid);

    q_data.vld[3]           = !halted_r && in_source_end && !term &&
                              (mode_mid != MODE_HEXPRE);
    q_data.tok[3].kind      = KIND_END;
    q_data.tok[3].start     = pos_a;
    q_data.tok[3].line      = line_a;
    q_data.tok[3].column    = col_a;
    q_data.tok[3].length    = '0;

    q_push = step_en && (q_data.vld != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      pos_r       <= '0;
      line_r      <= '0;
      col_r       <= '0;
      ost_r       <= '0;
      oln_r       <= '0;
      ocl_r       <= '0;
      lone_zero_r <= 1'b0;
      halted_r    <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      ost_r       <= ost_nxt;
      oln_r       <= oln_nxt;
      ocl_r       <= ocl_nxt;
      lone_zero_r <= lone_zero_nxt;
      halted_r    <= halted_nxt;
    end
  end

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !q_push)
    else $error("token produced while halted");

  a_max_three: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(q_data.vld) <= 3)
    else $error("more than three tokens for one character");

  a_error_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    (q_data.vld[1] && q_data.tok[1].kind == KIND_ERROR) |-> !q_data.vld[3])
    else $error("end token after an error token");

  a_halt_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && q_data.vld[1] && q_data.tok[1].kind == KIND_ERROR && !in_source_end)
      |=> halted_r)
    else $error("error token did not halt the scanner");

endmodule

// ----- src/asmtok_queue.sv -----
module asmtok_queue
  import asmtok_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  bundle_t  wr_data,
  output logic     full,
  input  logic     rd_en,
  output logic     empty,
  output bundle_t  rd_data
);

  bundle_t               mem_r [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                  do_wr, do_rd;

  assign full    = (cnt_r == QCNT_BITS'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_BITS'(do_wr) - QCNT_BITS'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("bundle written into a full queue");

  a_no_empty_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (rd_data.vld != '0))
    else $error("queued bundle carries no token");

endmodule

// ----- src/asmtok_back.sv -----
module asmtok_back
  import asmtok_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  bundle_t               q_data,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [KIND_BITS-1:0]  out_token_kind,
  output logic [POS_BITS-1:0]   out_token_start,
  output logic [LINE_BITS-1:0]  out_token_line,
  output logic [COL_BITS-1:0]   out_token_column,
  output logic [LEN_BITS-1:0]   out_token_length,
  output logic                  out_last_of_run
);

  bundle_t                bundle_r, bundle_nxt;
  logic [SLOTS-1:0]       mask_r, mask_nxt, mask_after;
  logic [SLOT_BITS-1:0]   sel;
  tok_t                   cur;

  // Pick the oldest remaining slot
  always_comb begin
    sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = SLOT_BITS'(i);
      end
    end
  end

  assign cur              = bundle_r.tok[sel];
  assign empty            = (mask_r == '0);
  assign out_token_kind   = cur.kind;
  assign out_token_start  = cur.start;
  assign out_token_line   = cur.line;
  assign out_token_column = cur.column;
  assign out_token_length = cur.length;
  assign out_last_of_run  = ((mask_r & (mask_r - 1'b1)) == '0);

  always_comb begin
    mask_after = mask_r;
    if (pop && !empty) begin
      mask_after[sel] = 1'b0;
    end
    // refill in the same cycle the last slot leaves
    q_pop      = (mask_after == '0) && !q_empty;
    mask_nxt   = q_pop ? q_data.vld : mask_after;
    bundle_nxt = q_pop ? q_data : bundle_r;
  end

  always_ff @(posedge clk) begin
    bundle_r <= bundle_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  a_load_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (mask_after == '0))
    else $error("bundle loaded over pending tokens");

endmodule

// ----- src/assembly_source_tokenizer_top.sv -----
// Channel   Handshake        Payload
// input     push / full      in_ch, in_source_end
// result    empty / pop      out_token_kind/start/line/column/length, out_last_of_run
//
// One character is taken per cycle while full is low; the scanner state updates in that cycle.
// Tokens leave one per cycle while pop is high; a character that closes and opens tokens,
// or ends the source, yields up to three, which leave on the result side in turn.
// A two-bundle queue between scanner and token sequencer absorbs those bursts; full
// rises only when it holds two bundles. A token shows after the queue and the bundle register.
// Synchronous reset clears the scanner, the queue and the pending tokens at once.
module assembly_source_tokenizer_top
  import asmtok_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_ch,
  input  logic                  in_source_end,
  output logic                  empty,
  input  logic                  pop,
  output logic [KIND_BITS-1:0]  out_token_kind,
  output logic [POS_BITS-1:0]   out_token_start,
  output logic [LINE_BITS-1:0]  out_token_line,
  output logic [COL_BITS-1:0]   out_token_column,
  output logic [LEN_BITS-1:0]   out_token_length,
  output logic                  out_last_of_run
);

  logic    step_en;
  logic    q_push, q_full, q_empty, q_pop;
  bundle_t q_wr_data, q_rd_data;

  assign full    = q_full;
  assign step_en = push && !q_full;

  asmtok_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .in_ch         (in_ch),
    .in_source_end (in_source_end),
    .q_push        (q_push),
    .q_data        (q_wr_data)
  );

  asmtok_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  asmtok_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_rd_data),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_line   (out_token_line),
    .out_token_column (out_token_column),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
